@@ hw/rtl/i2cm_pkg.sv @@
package i2cm_pkg;

    localparam logic [7:0] ACK_TIMEOUT_RST = 8'd250;
    localparam logic [2:0] LAST_BIT        = 3'd7;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_WAIT  = 3'd4,
        CMD_READ  = 3'd5
    } cmd_t;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_START0  = 5'd1,
        PH_START1  = 5'd2,
        PH_START2  = 5'd3,
        PH_STOP0   = 5'd4,
        PH_STOP1   = 5'd5,
        PH_STOP2   = 5'd6,
        PH_FAILEND = 5'd7,
        PH_WR_LOW  = 5'd8,
        PH_WR_HIGH = 5'd9,
        PH_WR_END  = 5'd10,
        PH_WA_REL  = 5'd11,
        PH_WA_HIGH = 5'd12,
        PH_WA_POLL = 5'd13,
        PH_RD_HIGH = 5'd14,
        PH_RD_LOW  = 5'd15,
        PH_ACK0    = 5'd16,
        PH_ACK1    = 5'd17,
        PH_ACK2    = 5'd18,
        PH_ACK3    = 5'd19
    } phase_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] write_data;
        logic       send_ack;
        logic       sda_in;
    } in_word_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_failed;
    } out_word_t;

endpackage

@@ hw/rtl/i2c_master_bit_sequencer_unit.sv @@
// channel   ports                      payload
// input     s_valid s_ready s_data     in_word_t  (one half-bit tick)
// result    m_valid m_ready m_data     out_word_t (bus levels and flags)
// config    cfg_wr_en cfg_wr_data      ack timeout, 8 bits
//
// one word per clock sustained while m_ready stays high; a result word is registered after its input word is taken
// the input register feeds the sequencer logic, which loads the result register
// while a result word waits, the input register holds one word and s_ready stays low
// until m_ready returns
// aresetn is synchronous active low; it clears the sequencer to idle, bus released
module i2c_master_bit_sequencer_unit
    import i2cm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  logic      cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);

    logic       in_valid_reg;
    in_word_t   in_data_reg;
    logic       out_valid_reg;
    out_word_t  out_data_reg;
    logic       advance;

    logic [7:0] ack_timeout_reg;
    phase_t     phase_reg, phase_next;
    cmd_t       op_reg, op_next;
    logic [2:0] bit_cnt_reg, bit_cnt_next;
    logic [7:0] shift_reg, shift_next;
    logic [7:0] poll_cnt_reg, poll_cnt_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       ack_fail_reg, ack_fail_next;
    logic [7:0] rd_data_reg, rd_data_next;
    logic       ack_sel_reg, ack_sel_next;

    phase_t     eff_phase;
    cmd_t       eff_op;
    logic [2:0] eff_bit_cnt;
    logic [7:0] eff_shift;
    logic [7:0] eff_poll_cnt;
    logic       eff_ack_sel;
    logic [7:0] poll_inc;
    logic       done;
    out_word_t  res;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_timeout_reg <= ACK_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            ack_timeout_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            op_reg       <= CMD_NONE;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            poll_cnt_reg <= '0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
            ack_fail_reg <= 1'b0;
            rd_data_reg  <= '0;
            ack_sel_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg    <= phase_next;
            op_reg       <= op_next;
            bit_cnt_reg  <= bit_cnt_next;
            shift_reg    <= shift_next;
            poll_cnt_reg <= poll_cnt_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
            ack_fail_reg <= ack_fail_next;
            rd_data_reg  <= rd_data_next;
            ack_sel_reg  <= ack_sel_next;
        end
    end

    // command capture on an idle tick
    always_comb begin
        eff_phase    = phase_reg;
        eff_op       = op_reg;
        eff_bit_cnt  = bit_cnt_reg;
        eff_shift    = shift_reg;
        eff_poll_cnt = poll_cnt_reg;
        eff_ack_sel  = ack_sel_reg;
        if (phase_reg == PH_IDLE) begin
            unique case (in_data_reg.command)
                CMD_START: eff_phase = PH_START0;
                CMD_STOP:  eff_phase = PH_STOP0;
                CMD_WRITE: begin
                    eff_phase = PH_WR_LOW;
                    eff_shift = in_data_reg.write_data;
                end
                CMD_WAIT:  eff_phase = PH_WA_REL;
                CMD_READ: begin
                    eff_phase   = PH_RD_HIGH;
                    eff_shift   = '0;
                    eff_ack_sel = in_data_reg.send_ack;
                end
                default: ;
            endcase
            if (eff_phase != PH_IDLE) begin
                eff_op       = cmd_t'(in_data_reg.command);
                eff_bit_cnt  = '0;
                eff_poll_cnt = '0;
            end
        end
    end

    assign poll_inc = eff_poll_cnt + 8'd1;

    // next state
    always_comb begin
        phase_next    = PH_IDLE;
        op_next       = eff_op;
        bit_cnt_next  = eff_bit_cnt;
        shift_next    = eff_shift;
        poll_cnt_next = eff_poll_cnt;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        ack_fail_next = ack_fail_reg;
        rd_data_next  = rd_data_reg;
        ack_sel_next  = eff_ack_sel;
        unique case (eff_phase)
            PH_IDLE: ;
            PH_START0: begin
                scl_next   = 1'b1;
                sda_next   = 1'b1;
                phase_next = PH_START1;
            end
            PH_START1: begin
                sda_next   = 1'b0;
                phase_next = PH_START2;
            end
            PH_START2: scl_next = 1'b0;
            PH_STOP0: begin
                sda_next   = 1'b0;
                phase_next = PH_STOP1;
            end
            PH_STOP1: begin
                scl_next   = 1'b1;
                phase_next = PH_STOP2;
            end
            PH_STOP2: begin
                sda_next = 1'b1;
                if (eff_op == CMD_WAIT) begin
                    phase_next = PH_FAILEND;
                end
            end
            PH_FAILEND, PH_WR_END, PH_WA_REL: begin
                scl_next = 1'b0;
                sda_next = 1'b1;
                if (eff_phase == PH_WA_REL) begin
                    phase_next = PH_WA_HIGH;
                end
            end
            PH_WR_LOW: begin
                scl_next   = 1'b0;
                sda_next   = eff_shift[7];
                phase_next = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
                scl_next   = 1'b1;
                shift_next = {eff_shift[6:0], 1'b0};
                if (eff_bit_cnt == LAST_BIT) begin
                    phase_next = PH_WR_END;
                end else begin
                    bit_cnt_next = eff_bit_cnt + 3'd1;
                    phase_next   = PH_WR_LOW;
                end
            end
            PH_WA_HIGH: begin
                scl_next   = 1'b1;
                phase_next = PH_WA_POLL;
            end
            PH_WA_POLL: begin
                if (!in_data_reg.sda_in) begin
                    scl_next      = 1'b0;
                    sda_next      = 1'b1;
                    ack_fail_next = 1'b0;
                end else begin
                    poll_cnt_next = poll_inc;
                    if (poll_inc > ack_timeout_reg) begin
                        // timeout: first stop step on this tick, scl stays high
                        ack_fail_next = 1'b1;
                        sda_next      = 1'b0;
                        phase_next    = PH_STOP1;
                    end else begin
                        phase_next = PH_WA_POLL;
                    end
                end
            end
            PH_RD_HIGH: begin
                scl_next   = 1'b1;
                sda_next   = 1'b1;
                shift_next = {eff_shift[6:0], in_data_reg.sda_in};
                phase_next = PH_RD_LOW;
            end
            PH_RD_LOW: begin
                scl_next = 1'b0;
                if (eff_bit_cnt == LAST_BIT) begin
                    rd_data_next = eff_shift;
                    phase_next   = PH_ACK0;
                end else begin
                    bit_cnt_next = eff_bit_cnt + 3'd1;
                    phase_next   = PH_RD_HIGH;
                end
            end
            PH_ACK0: begin
                scl_next   = 1'b0;
                sda_next   = !eff_ack_sel;
                phase_next = PH_ACK1;
            end
            PH_ACK1: begin
                scl_next   = 1'b1;
                phase_next = PH_ACK2;
            end
            PH_ACK2: begin
                scl_next = 1'b0;
                if (eff_ack_sel) begin
                    phase_next = PH_ACK3;
                end
            end
            PH_ACK3: sda_next = 1'b1;
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        unique case (eff_phase)
            PH_START2, PH_FAILEND, PH_WR_END, PH_ACK3: done = 1'b1;
            PH_STOP2:   done = (eff_op != CMD_WAIT);
            PH_WA_POLL: done = !in_data_reg.sda_in;
            PH_ACK2:    done = !eff_ack_sel;
            default:    done = 1'b0;
        endcase
        res.scl_out    = scl_next;
        res.sda_out    = sda_next;
        res.busy_res   = (phase_next != PH_IDLE);
        res.done_res   = done;
        res.read_data  = rd_data_next;
        res.ack_failed = ack_fail_next;
    end

`ifndef SYNTHESIS
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(phase_reg) && $stable(shift_reg))
        else $error("sequencer state moved without a word");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg)
        else $error("input stalled while a stage is free");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.done_res |-> !res.busy_res)
        else $error("done word still reports busy");

    a_fail_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ack_fail_reg) |-> op_reg == CMD_WAIT)
        else $error("ack failure outside wait-ack");
`endif

endmodule

@@ verif/i2c_master_bit_sequencer_unit_tb.sv @@
`timescale 1ns / 100ps

module i2c_master_bit_sequencer_unit_tb;
    import i2cm_pkg::*;

    localparam logic [2:0] CMD_RSV6 = 3'd6;
    localparam logic [2:0] CMD_RSV7 = 3'd7;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    in_word_t   s_data = '0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    out_word_t  m_data;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;

    // bus sequencer model state
    phase_t     bus_phase;
    cmd_t       bus_op;
    logic [2:0] bit_idx;
    logic [7:0] shift_q;
    logic [7:0] poll_cnt;
    logic       scl_q;
    logic       sda_q;
    logic       ack_fail_q;
    logic [7:0] read_byte_q;
    logic       ack_sel_q;
    logic [7:0] ack_timeout_q;

    out_word_t  expected_ticks[$];
    out_word_t  want;
    int         mismatch_count = 0;
    int         ticks_sent = 0;
    bit         source_gaps_on = 1'b1;
    bit         sink_stalls_on = 1'b1;
    int         hold_left = 0;
    int         stall_left = 0;

    i2c_master_bit_sequencer_unit uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    function automatic void clear_bus_model();
        bus_phase     = PH_IDLE;
        bus_op        = CMD_NONE;
        bit_idx       = 3'd0;
        shift_q       = 8'd0;
        poll_cnt      = 8'd0;
        scl_q         = 1'b1;
        sda_q         = 1'b1;
        ack_fail_q    = 1'b0;
        read_byte_q   = 8'd0;
        ack_sel_q     = 1'b0;
        ack_timeout_q = ACK_TIMEOUT_RST;
    endfunction

    // bus levels and flags for one tick
    function automatic out_word_t predict_bus_tick(input in_word_t w);
        out_word_t o;
        logic      done;
        done = 1'b0;
        if (bus_phase == PH_IDLE && w.command >= CMD_START && w.command <= CMD_READ) begin
            bus_op   = cmd_t'(w.command);
            bit_idx  = 3'd0;
            poll_cnt = 8'd0;
            case (cmd_t'(w.command))
                CMD_START: bus_phase = PH_START0;
                CMD_STOP:  bus_phase = PH_STOP0;
                CMD_WRITE: begin
                    shift_q   = w.write_data;
                    bus_phase = PH_WR_LOW;
                end
                CMD_WAIT:  bus_phase = PH_WA_REL;
                default: begin
                    shift_q   = 8'd0;
                    ack_sel_q = w.send_ack;
                    bus_phase = PH_RD_HIGH;
                end
            endcase
        end
        case (bus_phase)
            PH_IDLE: ;
            PH_START0: begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                bus_phase = PH_START1;
            end
            PH_START1: begin
                sda_q = 1'b0;
                bus_phase = PH_START2;
            end
            PH_START2: begin
                scl_q = 1'b0;
                bus_phase = PH_IDLE;
                done = 1'b1;
            end
            PH_STOP0: begin
                sda_q = 1'b0;
                bus_phase = PH_STOP1;
            end
            PH_STOP1: begin
                scl_q = 1'b1;
                bus_phase = PH_STOP2;
            end
            PH_STOP2: begin
                sda_q = 1'b1;
                if (bus_op == CMD_WAIT) begin
                    bus_phase = PH_FAILEND;
                end else begin
                    bus_phase = PH_IDLE;
                    done = 1'b1;
                end
            end
            PH_FAILEND: begin
                scl_q = 1'b0;
                sda_q = 1'b1;
                bus_phase = PH_IDLE;
                done = 1'b1;
            end
            PH_WR_LOW: begin
                scl_q = 1'b0;
                sda_q = shift_q[7];
                bus_phase = PH_WR_HIGH;
            end
            PH_WR_HIGH: begin
                scl_q = 1'b1;
                shift_q = {shift_q[6:0], 1'b0};
                if (bit_idx == LAST_BIT) begin
                    bus_phase = PH_WR_END;
                end else begin
                    bit_idx = bit_idx + 3'd1;
                    bus_phase = PH_WR_LOW;
                end
            end
            PH_WR_END: begin
                scl_q = 1'b0;
                sda_q = 1'b1;
                bus_phase = PH_IDLE;
                done = 1'b1;
            end
            PH_WA_REL: begin
                scl_q = 1'b0;
                sda_q = 1'b1;
                bus_phase = PH_WA_HIGH;
            end
            PH_WA_HIGH: begin
                scl_q = 1'b1;
                bus_phase = PH_WA_POLL;
            end
            PH_WA_POLL: begin
                if (!w.sda_in) begin
                    scl_q = 1'b0;
                    sda_q = 1'b1;
                    ack_fail_q = 1'b0;
                    bus_phase = PH_IDLE;
                    done = 1'b1;
                end else begin
                    poll_cnt = poll_cnt + 8'd1;
                    // timeout: stop begins on this tick with scl still high
                    if (poll_cnt > ack_timeout_q) begin
                        ack_fail_q = 1'b1;
                        sda_q = 1'b0;
                        bus_phase = PH_STOP1;
                    end
                end
            end
            PH_RD_HIGH: begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                shift_q = {shift_q[6:0], w.sda_in};
                bus_phase = PH_RD_LOW;
            end
            PH_RD_LOW: begin
                scl_q = 1'b0;
                if (bit_idx == LAST_BIT) begin
                    read_byte_q = shift_q;
                    bus_phase = PH_ACK0;
                end else begin
                    bit_idx = bit_idx + 3'd1;
                    bus_phase = PH_RD_HIGH;
                end
            end
            PH_ACK0: begin
                scl_q = 1'b0;
                sda_q = ~ack_sel_q;
                bus_phase = PH_ACK1;
            end
            PH_ACK1: begin
                scl_q = 1'b1;
                bus_phase = PH_ACK2;
            end
            PH_ACK2: begin
                scl_q = 1'b0;
                if (ack_sel_q) begin
                    bus_phase = PH_ACK3;
                end else begin
                    bus_phase = PH_IDLE;
                    done = 1'b1;
                end
            end
            PH_ACK3: begin
                sda_q = 1'b1;
                bus_phase = PH_IDLE;
                done = 1'b1;
            end
            default: bus_phase = PH_IDLE;
        endcase
        o.scl_out    = scl_q;
        o.sda_out    = sda_q;
        o.busy_res   = (bus_phase != PH_IDLE);
        o.done_res   = done;
        o.read_data  = read_byte_q;
        o.ack_failed = ack_fail_q;
        return o;
    endfunction

    // result side: random stall bursts plus the long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if (sink_stalls_on && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 11);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_ticks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word %h at %0t", m_data, $time);
            end else begin
                want = expected_ticks.pop_front();
                if (m_data.scl_out !== want.scl_out || m_data.sda_out !== want.sda_out ||
                    m_data.busy_res !== want.busy_res || m_data.done_res !== want.done_res ||
                    m_data.read_data !== want.read_data ||
                    m_data.ack_failed !== want.ack_failed) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch at %0t: expected %h, got %h", $time, want, m_data);
                end
            end
        end
    end

    task automatic send_tick(input in_word_t w);
        int gap;
        @(negedge aclk);
        if (source_gaps_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_ticks.push_back(predict_bus_tick(w));
        ticks_sent++;
    endtask

    // one command word, then ticks until the sequencer is idle again
    task automatic issue(input logic [2:0] cmd, input logic [7:0] wdata, input logic ack,
                         input logic [7:0] rd_bits, input int ack_delay);
        in_word_t w;
        int       polls_sent;
        polls_sent   = 0;
        w.command    = cmd;
        w.write_data = wdata;
        w.send_ack   = ack;
        w.sda_in     = (cmd == CMD_READ && bus_phase == PH_IDLE) ? rd_bits[7] : 1'($urandom);
        send_tick(w);
        while (bus_phase != PH_IDLE) begin
            // commands while busy must be ignored
            w.command    = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
            w.write_data = 8'($urandom);
            w.send_ack   = 1'($urandom);
            if (bus_phase == PH_RD_HIGH) begin
                w.sda_in = rd_bits[~bit_idx];
            end else if (bus_phase == PH_WA_POLL) begin
                w.sda_in = (polls_sent < ack_delay);
                polls_sent++;
            end else begin
                w.sda_in = 1'($urandom);
            end
            send_tick(w);
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(negedge aclk);
    endtask

    task automatic set_ack_timeout(input logic [7:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        ack_timeout_q = value;
    endtask

    task automatic random_transfer();
        int n;
        int lim;
        lim = (ack_timeout_q < 8'd22) ? int'(ack_timeout_q) + 2 : 24;
        if ($urandom_range(0, 5) == 0) begin
            // stray command of any code, outside a framed transfer
            issue(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), 8'($urandom),
                  $urandom_range(0, lim));
        end else begin
            issue(CMD_START, 8'($urandom), 1'($urandom), 8'($urandom), 0);
            issue(CMD_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), 0);
            issue(CMD_WAIT, 8'($urandom), 1'($urandom), 8'($urandom), $urandom_range(0, lim));
            n = $urandom_range(0, 3);
            repeat (n) begin
                if ($urandom_range(0, 1) == 0) begin
                    issue(CMD_WRITE, 8'($urandom), 1'($urandom), 8'($urandom), 0);
                    issue(CMD_WAIT, 8'($urandom), 1'($urandom), 8'($urandom),
                          $urandom_range(0, lim));
                end else begin
                    issue(CMD_READ, 8'($urandom), 1'($urandom), 8'($urandom), 0);
                end
            end
            if ($urandom_range(0, 7) != 0)
                issue(CMD_STOP, 8'($urandom), 1'($urandom), 8'($urandom), 0);
        end
    endtask

    task automatic test_idle_codes();
        issue(CMD_NONE, 8'h00, 1'b0, 8'h00, 0);
        issue(CMD_RSV6, 8'hFF, 1'b1, 8'h00, 0);
        issue(CMD_RSV7, 8'h5A, 1'b0, 8'h00, 0);
    endtask

    task automatic test_start_stop();
        issue(CMD_START, 8'h00, 1'b0, 8'h00, 0);
        issue(CMD_STOP, 8'h00, 1'b0, 8'h00, 0);
        issue(CMD_STOP, 8'hFF, 1'b1, 8'h00, 0);
        issue(CMD_START, 8'h00, 1'b0, 8'h00, 0);
        issue(CMD_START, 8'h00, 1'b0, 8'h00, 0);
    endtask

    task automatic test_write_bytes();
        issue(CMD_WRITE, 8'hFF, 1'b0, 8'h00, 0);
        issue(CMD_WRITE, 8'hA5, 1'b1, 8'h00, 0);
    endtask

    task automatic test_read_bytes();
        issue(CMD_READ, 8'h00, 1'b1, 8'hFF, 0);
        issue(CMD_READ, 8'hFF, 1'b0, 8'h00, 0);
        issue(CMD_READ, 8'h00, 1'b0, 8'hA5, 0);
    endtask

    task automatic test_ack_wait();
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 0);
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 5);
        set_ack_timeout(8'd0);
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 0);
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 1);
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 0);
        set_ack_timeout(8'd3);
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 3);
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 4);
        issue(CMD_READ, 8'h00, 1'b1, 8'h3C, 0);
        // poll count wraps, so only a low sda ends the wait
        set_ack_timeout(8'd255);
        issue(CMD_WAIT, 8'h00, 1'b0, 8'h00, 258);
    endtask

    task automatic test_output_backpressure();
        set_ack_timeout(8'd250);
        hold_left = 80;
        issue(CMD_START, 8'h00, 1'b0, 8'h00, 0);
        issue(CMD_WRITE, 8'($urandom), 1'b0, 8'h00, 0);
        issue(CMD_READ, 8'h00, 1'b1, 8'($urandom), 0);
    endtask

    task automatic test_random_transfers();
        int target;
        target = ticks_sent + 30;
        while (ticks_sent < target) begin
            if ($urandom_range(0, 5) == 0) begin
                case ($urandom_range(0, 4))
                    0: set_ack_timeout(8'd0);
                    1: set_ack_timeout(8'd1);
                    2: set_ack_timeout(8'($urandom_range(2, 20)));
                    3: set_ack_timeout(8'($urandom_range(200, 255)));
                    default: set_ack_timeout(8'($urandom_range(0, 10)));
                endcase
            end
            random_transfer();
        end
    endtask

    task automatic test_random_no_idle();
        int target;
        drain_results();
        source_gaps_on = 1'b0;
        sink_stalls_on = 1'b0;
        set_ack_timeout(8'($urandom_range(0, 12)));
        target = ticks_sent + 30;
        while (ticks_sent < target)
            random_transfer();
    endtask

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        clear_bus_model();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_codes();
        test_start_stop();
        test_write_bytes();
        test_read_bytes();
        test_ack_wait();
        test_output_backpressure();
        test_random_transfers();
        test_random_no_idle();
        drain_results();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && expected_ticks.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/i2cm_pkg.sv
hw/rtl/i2c_master_bit_sequencer_unit.sv
verif/i2c_master_bit_sequencer_unit_tb.sv
